FILE: rtl/core/otu_pkg.sv
// Shared constants for the output tile unpadder: tile geometry, field widths,
// configuration register indexes and reset values. No dependencies.
package otu_pkg;

  // Tile geometry: 8 by 8 words, column-major inside a tile
  localparam int TILE_EDGE    = 8;
  localparam int TILE_EDGE_W  = $clog2(TILE_EDGE);
  localparam int TILE_WORDS   = TILE_EDGE * TILE_EDGE;
  localparam int WORD_POS_W   = $clog2(TILE_WORDS);

  // Field widths
  localparam int WORD_W       = 32;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;

  // Reset values of the dimension registers
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 13'd8;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 13'd8;

  // Default upper bound on either matrix dimension
  localparam int MAX_DIM_DEFAULT = 4096;

endpackage

FILE: rtl/core/output_tile_unpadder_core.sv
// Output tile unpadder top level: drops padding words from a tiled result stream.
// Depends on otu_pkg for tile geometry, widths and register indexes.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word_value) carries the words of a
//   result matrix in tile order: 64 words per 8x8 tile, column-major inside a
//   tile, tiles down the tile rows first, then across the tile columns.
//   Output channel (out_valid / out_stall / out_kept_value) carries only the
//   words that lie inside matrix_rows x matrix_cols; padding beats are absorbed.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   matrix_rows (index 0) or matrix_cols (index 1); cfg_ready is always high.
//   Writes are expected only while the block is idle.
// Timing:
//   One input beat per cycle while not stalled. A kept word shows up on the
//   output in the cycle after its input beat, from a single output register.
//   Input stalls only while that register holds a word the receiver stalls on.
// Reset:
//   Tile and word counters return to zero, both dimensions to 8, output empty.
//   After the last word of the last tile the counters wrap to zero for the next
//   matrix.
module output_tile_unpadder_core #(
  parameter int MAX_DIM = otu_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [otu_pkg::WORD_W-1:0]   in_word_value,
  // kept words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [otu_pkg::WORD_W-1:0]   out_kept_value,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [otu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [otu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Derived widths
  localparam int MAX_TILES = (MAX_DIM + otu_pkg::TILE_EDGE - 1) / otu_pkg::TILE_EDGE;
  localparam int TCW       = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int DIM_NEED  = $clog2(MAX_DIM + 1);
  localparam int DW        = (DIM_NEED > otu_pkg::CFG_DATA_W) ? DIM_NEED
                                                              : otu_pkg::CFG_DATA_W;
  localparam int EW        = otu_pkg::TILE_EDGE_W;
  localparam int PW        = otu_pkg::WORD_POS_W;

  // Registers
  logic [otu_pkg::CFG_DATA_W-1:0]     rows_r, cols_r;
  logic [TCW-1:0]                     tile_row_r, tile_row_nxt;
  logic [TCW-1:0]                     tile_col_r, tile_col_nxt;
  logic [PW-1:0]                      word_pos_r, word_pos_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [otu_pkg::WORD_W-1:0]  out_value_r;

  // Datapath signals
  logic                in_accept;
  logic [DW-1:0]       rows_eff, cols_eff;
  logic [DW-1:0]       rows_last_idx, cols_last_idx;
  logic                row_is_last, col_is_last;
  logic [EW:0]         row_extent, col_extent;
  logic [EW-1:0]       word_row, word_col;
  logic                keep;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign out_valid      = out_valid_r;
  assign out_kept_value = out_value_r;

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    rows_eff = DW'(rows_r);
    cols_eff = DW'(cols_r);
    if (rows_r == '0) begin
      rows_eff = DW'(1);
    end else if (DW'(rows_r) > DW'(MAX_DIM)) begin
      rows_eff = DW'(MAX_DIM);
    end
    if (cols_r == '0) begin
      cols_eff = DW'(1);
    end else if (DW'(cols_r) > DW'(MAX_DIM)) begin
      cols_eff = DW'(MAX_DIM);
    end
  end

  // Last tile index = (dim - 1) / 8; counters at or past it count as last
  assign rows_last_idx = (rows_eff - DW'(1)) >> EW;
  assign cols_last_idx = (cols_eff - DW'(1)) >> EW;
  assign row_is_last   = DW'(tile_row_r) >= rows_last_idx;
  assign col_is_last   = DW'(tile_col_r) >= cols_last_idx;

  // Kept extent in the current tile: remainder in the last tile, else full edge
  always_comb begin
    row_extent = (EW+1)'(otu_pkg::TILE_EDGE);
    col_extent = (EW+1)'(otu_pkg::TILE_EDGE);
    if (row_is_last && (rows_eff[EW-1:0] != '0)) begin
      row_extent = {1'b0, rows_eff[EW-1:0]};
    end
    if (col_is_last && (cols_eff[EW-1:0] != '0)) begin
      col_extent = {1'b0, cols_eff[EW-1:0]};
    end
  end

  // Column-major position inside the tile
  assign word_row = word_pos_r[EW-1:0];
  assign word_col = word_pos_r[PW-1:EW];
  assign keep     = ({1'b0, word_row} < row_extent) && ({1'b0, word_col} < col_extent);

  // Counter advance per accepted beat
  always_comb begin
    tile_row_nxt = tile_row_r;
    tile_col_nxt = tile_col_r;
    word_pos_nxt = word_pos_r;
    if (in_accept) begin
      word_pos_nxt = word_pos_r + PW'(1);
      if (word_pos_r == PW'(otu_pkg::TILE_WORDS - 1)) begin
        word_pos_nxt = '0;
        if (row_is_last) begin
          tile_row_nxt = '0;
          tile_col_nxt = col_is_last ? '0 : tile_col_r + TCW'(1);
        end else begin
          tile_row_nxt = tile_row_r + TCW'(1);
        end
      end
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) begin
      out_valid_nxt = keep;
    end
  end

  // Control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= otu_pkg::ROWS_RESET;
      cols_r      <= otu_pkg::COLS_RESET;
      tile_row_r  <= '0;
      tile_col_r  <= '0;
      word_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tile_row_r  <= tile_row_nxt;
      tile_col_r  <= tile_col_nxt;
      word_pos_r  <= word_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          otu_pkg::REG_MATRIX_ROWS: rows_r <= cfg_data;
          otu_pkg::REG_MATRIX_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Output payload, loaded with each kept beat
  always_ff @(posedge clk) begin
    if (in_accept && keep) begin
      out_value_r <= in_word_value;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for output_tile_unpadder_core: a scoreboard tracks the tile and word
// position, predicts which words survive padding removal and checks each kept beat.
// Depends on otu_pkg and the core RTL.
module testbench;

  localparam int MAX_DIM     = otu_pkg::MAX_DIM_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1800;
  localparam int LONG_HOLD   = 400;
  localparam int PRINT_CAP   = 100;
  localparam int DIM_CEILING = (1 << otu_pkg::CFG_DATA_W) - 1;

  // Indexes past the register list; writes there must be dropped
  localparam logic [otu_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [otu_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic signed [otu_pkg::WORD_W-1:0] word_t;
  typedef logic [otu_pkg::CFG_DATA_W-1:0]    dim_t;

  // Scoreboard: own copy of dimension registers and tile counters
  class unpad_scoreboard;
    dim_t  rows_reg;
    dim_t  cols_reg;
    int    tile_row;
    int    tile_col;
    int    word_pos;
    word_t kept_q[$];
    int    errors;

    function new();
      rows_reg = otu_pkg::ROWS_RESET;
      cols_reg = otu_pkg::COLS_RESET;
      tile_row = 0;
      tile_col = 0;
      word_pos = 0;
      errors   = 0;
    endfunction

    function void report(string msg);
      if (errors < PRINT_CAP) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
      errors++;
    endfunction

    // zero reads as one, anything past MAX_DIM saturates
    function int clamp_dim(dim_t v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int tile_count(int dim);
      return (dim + otu_pkg::TILE_EDGE - 1) / otu_pkg::TILE_EDGE;
    endfunction

    // rows (or columns) kept in the tile at pos; last tile keeps the remainder
    function int edge_extent(int pos, int dim);
      int rem;
      rem = dim % otu_pkg::TILE_EDGE;
      if (pos + 1 >= tile_count(dim) && rem != 0) return rem;
      return otu_pkg::TILE_EDGE;
    endfunction

    function void write_reg(logic [otu_pkg::CFG_IDX_W-1:0] idx, dim_t data);
      case (idx)
        otu_pkg::REG_MATRIX_ROWS: rows_reg = data;
        otu_pkg::REG_MATRIX_COLS: cols_reg = data;
        default: ;
      endcase
    endfunction

    // accepted input beat: queue it if inside the matrix, then advance counters
    function void note_word(word_t v);
      int rows;
      int cols;
      int r;
      int c;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      r = word_pos % otu_pkg::TILE_EDGE;
      c = word_pos / otu_pkg::TILE_EDGE;
      if (r < edge_extent(tile_row, rows) && c < edge_extent(tile_col, cols)) begin
        kept_q.push_back(v);
      end
      if (word_pos + 1 >= otu_pkg::TILE_WORDS) begin
        word_pos = 0;
        // counts past the last tile (after a shrink) wrap like the last tile
        if (tile_row + 1 >= tile_count(rows)) begin
          tile_row = 0;
          if (tile_col + 1 >= tile_count(cols)) tile_col = 0;
          else tile_col++;
        end else begin
          tile_row++;
        end
      end else begin
        word_pos++;
      end
    endfunction

    function void check_kept(word_t got);
      word_t exp_word;
      if (kept_q.size() == 0) begin
        report($sformatf("kept beat %h with nothing outstanding", got));
      end else begin
        exp_word = kept_q.pop_front();
        if (got !== exp_word) begin
          report($sformatf("kept_value %h, predicted %h", got, exp_word));
        end
      end
    endfunction

    function int pending();
      return kept_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  word_t                         in_word_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  word_t                         out_kept_value;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [otu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  dim_t                          cfg_data = '0;

  unpad_scoreboard sb;
  int items_sent = 0;
  int cycle_cnt = 0;

  // receiver stall state
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  output_tile_unpadder_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word_value  (in_word_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kept_value (out_kept_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_kept(out_kept_value);
  end

  // receiver: long hold-off on request, otherwise stall modes of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // one input beat, held until accepted
  task automatic send_word(word_t v);
    in_valid <= 1'b1;
    in_word_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_word(v);
    items_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // config write; valid stays high so back-to-back writes need no re-raise
  task automatic write_reg(logic [otu_pkg::CFG_IDX_W-1:0] idx, dim_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // wait for every kept word, then let trailing padding beats settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(otu_pkg::WORD_W-1){1'b0}}};
      1: return {1'b0, {(otu_pkg::WORD_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // mostly small matrices so tiles wrap often; extremes now and then
  function automatic dim_t pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return dim_t'(MAX_DIM);
      2: return dim_t'($urandom_range(MAX_DIM + 1, DIM_CEILING));
      3: return dim_t'(1);
      4: return dim_t'(otu_pkg::TILE_EDGE * $urandom_range(1, 4));
      default: return dim_t'($urandom_range(1, 40));
    endcase
  endfunction

  // beats in bursts of random length with random gaps
  task automatic send_run(int n);
    int done;
    int burst;
    done = 0;
    while (done < n) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      while (burst > 0 && done < n) begin
        send_word(rand_word());
        burst--;
        done++;
      end
      if (done < n && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    word_t corner_words[4];
    int phase;
    int i;
    corner_words = '{{1'b1, {(otu_pkg::WORD_W-1){1'b0}}},
                     {1'b0, {(otu_pkg::WORD_W-1){1'b1}}}, '0, '1};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 8x8: the first tile is kept whole
    for (i = 0; i < 4; i++) send_word(corner_words[i]);

    // zero rows read as one, oversized columns saturate; mid-tile change
    drain();
    write_reg(otu_pkg::REG_MATRIX_ROWS, '0);
    write_reg(otu_pkg::REG_MATRIX_COLS, dim_t'(DIM_CEILING));
    cfg_valid <= 1'b0;
    for (i = 0; i < 12; i++) send_word(i[0] ? word_t'(32'h5555_5555) : word_t'(32'hAAAA_AAAA));

    // writes past the register list are dropped
    drain();
    write_reg(REG_SPARE_2, dim_t'(DIM_CEILING));
    write_reg(REG_SPARE_3, '0);
    write_reg(otu_pkg::REG_MATRIX_ROWS, dim_t'(MAX_DIM + 1));
    write_reg(otu_pkg::REG_MATRIX_COLS, dim_t'(1));
    cfg_valid <= 1'b0;
    for (i = 0; i < 8; i++) send_word(rand_word());

    // random phases; counters carry over, so shrinks land mid-matrix
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      if ($urandom_range(0, 1)) write_reg(otu_pkg::REG_MATRIX_ROWS, pick_dim());
      if ($urandom_range(0, 1)) write_reg(otu_pkg::REG_MATRIX_COLS, pick_dim());
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, dim_t'($urandom));
      end
      cfg_valid <= 1'b0;
      if (phase == 3) begin
        // receiver holds off while beats keep coming, so the input side backs up
        hold_req <= hold_req + 1;
        send_run(200);
      end else begin
        send_run($urandom_range(1, 250));
      end
      phase++;
    end

    drain();
    repeat (6) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d kept words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
